// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the timer bank RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define OTB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant violated");
// same-cycle implication
`define OTB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
// next-cycle implication
`define OTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");
`else
`define OTB_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define OTB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OTB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/otb_pkg.sv =====
// Package for the one-shot timer bank: widths, codes, shared structs.
// No dependencies; used by every other file of the block but assert_macros.svh.
package otb_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int NUM_DEST_DEF  = 16;
    localparam int MAX_RESULTS   = 16;

    localparam int TIME_W = 32;
    localparam int DEST_W = 4;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 16;
    localparam int MS_W   = 10;
    localparam int KIND_W = 2;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [MS_W-1:0] MS_PER_TICK_RST = MS_W'(10);

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT   = 2'd0,
        KIND_NOFREE  = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic advance;
        logic clear;
        logic arm_mode;
    } cell_ctrl_t;

    // what a cell reports when it holds the token and matches
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [DEST_W-1:0] target;
    } cell_hit_t;

endpackage

// ===== rtl/otb_req_if.sv =====
// Request channel of the timer bank: valid/ready plus one input item.
// Depends on otb_pkg for field widths.
interface otb_req_if import otb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] duration_ms;
    logic [DEST_W-1:0] destination;
    logic [MASK_W-1:0] destination_full;

    modport source (output valid, action, duration_ms, destination, destination_full,
                    input ready);
    modport sink (input valid, action, duration_ms, destination, destination_full,
                  output ready);
endinterface

// ===== rtl/otb_rsp_if.sv =====
// Result channel of the timer bank: valid/ready plus one result item.
// Depends on otb_pkg for field widths.
interface otb_rsp_if import otb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [DEST_W-1:0] target;
    logic              last;

    modport source (output valid, kind, slot, target, last, input ready);
    modport sink (input valid, kind, slot, target, last, output ready);
endinterface

// ===== rtl/otb_cfg_if.sv =====
// Configuration write channel: valid/ready plus the ms_per_tick value.
// Depends on otb_pkg for the register width.
interface otb_cfg_if import otb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [MS_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/otb_cell.sv =====
// One timer slot of the bank: armed flag, start time, duration, target,
// and one stage of the scan token chain. Depends on otb_pkg.
module otb_cell import otb_pkg::*; #(
    parameter int ID               = 0,
    parameter int NUM_DESTINATIONS = NUM_DEST_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] duration_ms,
    input  logic [DEST_W-1:0] destination,
    input  logic [MASK_W-1:0] full_mask,
    input  logic              token_in,
    output logic              token_out,
    output cell_hit_t         hit
);

    logic              armed_reg, armed_next;
    logic              token_reg, token_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [DEST_W-1:0] target_reg;

    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic              dest_ok;
    logic              match;
    logic              take;

    assign elapsed = now_ms - start_reg;
    assign due     = (elapsed >= dur_reg);
    // destinations outside the configured range always accept
    assign dest_ok = ({1'b0, target_reg} < (DEST_W+1)'(NUM_DESTINATIONS)) ?
                     !full_mask[target_reg] : 1'b1;

    always_comb
    begin
        if (ctrl.arm_mode)
        begin
            match = token_reg && !armed_reg;
        end
        else
        begin
            match = token_reg && armed_reg && due && dest_ok;
        end
        take       = match && ctrl.advance;
        armed_next = take ? ctrl.arm_mode : armed_reg;
        if (ctrl.clear)
        begin
            token_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            token_next = token_in;
        end
        else
        begin
            token_next = token_reg;
        end
    end

    assign hit.hit    = match;
    assign hit.slot   = match ? SLOT_W'(ID) : '0;
    assign hit.target = match ? target_reg : '0;
    assign token_out  = token_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            token_reg <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ctrl.arm_mode)
        begin
            start_reg  <= now_ms;
            dur_reg    <= duration_ms;
            target_reg <= destination;
        end
    end

endmodule

// ===== rtl/otb_ctrl.sv =====
// Sequencer of the timer bank: request capture, time base multiply,
// scan control, result buffering and the ms_per_tick register.
// Depends on otb_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"
module otb_ctrl import otb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    otb_req_if.sink           req,
    otb_rsp_if.source         rsp,
    otb_cfg_if.sink           cfg,
    input  cell_hit_t         hit_any,
    input  logic              token_exit,
    output cell_ctrl_t        cell_ctrl,
    output logic              token_start,
    output logic [TIME_W-1:0] now_ms,
    output logic [TIME_W-1:0] duration_ms,
    output logic [DEST_W-1:0] destination,
    output logic [MASK_W-1:0] full_mask
);

    localparam int PROD_W = TIME_W + MS_W;

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] tick_count_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [TIME_W-1:0] now_reg;
    logic              arm_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [DEST_W-1:0] dest_reg;
    logic [MASK_W-1:0] full_reg;
    logic [CNT_W-1:0]  n_reg, n_next;

    // held result: the newest result, sent once the next one shows whether it is last
    logic              h_valid_reg, h_valid_next;
    kind_t             h_kind_reg, h_kind_next;
    logic [SLOT_W-1:0] h_slot_reg, h_slot_next;
    logic [DEST_W-1:0] h_target_reg, h_target_next;

    logic              o_valid_reg, o_valid_next;
    kind_t             o_kind_reg, o_kind_next;
    logic [SLOT_W-1:0] o_slot_reg, o_slot_next;
    logic [DEST_W-1:0] o_target_reg, o_target_next;
    logic              o_last_reg, o_last_next;

    logic              req_fire;
    logic              o_free;
    logic [PROD_W-1:0] prod;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign o_free    = !o_valid_reg || rsp.ready;
    assign prod      = PROD_W'(tick_count_reg) * PROD_W'(ms_reg);

    assign now_ms      = now_reg;
    assign duration_ms = dur_reg;
    assign destination = dest_reg;
    assign full_mask   = full_reg;

    assign rsp.valid  = o_valid_reg;
    assign rsp.kind   = o_kind_reg;
    assign rsp.slot   = o_slot_reg;
    assign rsp.target = o_target_reg;
    assign rsp.last   = o_last_reg;

    always_comb
    begin
        state_next         = state_reg;
        n_next             = n_reg;
        token_start        = 1'b0;
        cell_ctrl.advance  = 1'b0;
        cell_ctrl.clear    = 1'b0;
        cell_ctrl.arm_mode = arm_reg;
        h_valid_next       = h_valid_reg;
        h_kind_next        = h_kind_reg;
        h_slot_next        = h_slot_reg;
        h_target_next      = h_target_reg;
        o_valid_next       = o_valid_reg && !rsp.ready;
        o_kind_next        = o_kind_reg;
        o_slot_next        = o_slot_reg;
        o_target_next      = o_target_reg;
        o_last_next        = o_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    n_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // load the token into the first cell
                token_start       = 1'b1;
                cell_ctrl.advance = 1'b1;
                state_next        = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit_any.hit)
                begin
                    if (!h_valid_reg || o_free)
                    begin
                        if (h_valid_reg)
                        begin
                            o_valid_next  = 1'b1;
                            o_kind_next   = h_kind_reg;
                            o_slot_next   = h_slot_reg;
                            o_target_next = h_target_reg;
                            o_last_next   = 1'b0;
                        end
                        cell_ctrl.advance = 1'b1;
                        h_valid_next      = 1'b1;
                        h_kind_next       = arm_reg ? KIND_GRANT : KIND_EXPIRED;
                        h_slot_next       = hit_any.slot;
                        h_target_next     = arm_reg ? '0 : hit_any.target;
                        n_next            = n_reg + CNT_W'(1);
                        if (arm_reg || (n_reg == CNT_W'(MAX_RESULTS - 1)))
                        begin
                            cell_ctrl.clear = 1'b1;
                            state_next      = ST_FLUSH;
                        end
                        else if (token_exit)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
                else
                begin
                    cell_ctrl.advance = 1'b1;
                    if (token_exit)
                    begin
                        state_next = ST_FLUSH;
                        if (arm_reg)
                        begin
                            h_valid_next  = 1'b1;
                            h_kind_next   = KIND_NOFREE;
                            h_slot_next   = '0;
                            h_target_next = '0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!h_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (o_free)
                begin
                    o_valid_next  = 1'b1;
                    o_kind_next   = h_kind_reg;
                    o_slot_next   = h_slot_reg;
                    o_target_next = h_target_reg;
                    o_last_next   = 1'b1;
                    h_valid_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= '0;
            ms_reg         <= MS_PER_TICK_RST;
            n_reg          <= '0;
            h_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            h_valid_reg <= h_valid_next;
            o_valid_reg <= o_valid_next;
            if (req_fire && !req.action)
            begin
                tick_count_reg <= tick_count_reg + TIME_W'(1);
            end
            if (cfg.valid)
            begin
                ms_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            arm_reg  <= req.action;
            dur_reg  <= req.duration_ms;
            dest_reg <= req.destination;
            full_reg <= req.destination_full;
        end
        if (state_reg == ST_MUL)
        begin
            now_reg <= prod[TIME_W-1:0];
        end
        h_kind_reg   <= h_kind_next;
        h_slot_reg   <= h_slot_next;
        h_target_reg <= h_target_next;
        o_kind_reg   <= o_kind_next;
        o_slot_reg   <= o_slot_next;
        o_target_reg <= o_target_next;
        o_last_reg   <= o_last_next;
    end

    `OTB_ASSERT_IMPL(a_hit_in_scan, clk, rst_n, hit_any.hit, state_reg == ST_SCAN)
    `OTB_ASSERT_ALWAYS(a_idle_no_held, clk, rst_n, (state_reg != ST_IDLE) || !h_valid_reg)
    `OTB_ASSERT_NEXT(a_arm_one_grant, clk, rst_n, (state_reg == ST_SCAN) && arm_reg && hit_any.hit && cell_ctrl.advance, state_reg == ST_FLUSH)
    `OTB_ASSERT_ALWAYS(a_count_bound, clk, rst_n, n_reg <= CNT_W'(MAX_RESULTS))

endmodule

// ===== rtl/oneshot_timer_bank.sv =====
// One-shot timer bank, top level.
// Channels: req (action, duration_ms, destination, destination_full), rsp
// (kind, slot, target, last), cfg (ms_per_tick write, always ready).
// Each request is accepted only while the bank is idle. After acceptance
// the ST_MUL state forms the time base (tick count times ms_per_tick),
// then a token walks the slot cells from slot 0 upwards, one slot per
// cycle while rsp does not stall it. An arm request stops at the first
// free slot and gives one result; a tick visits every slot and gives one
// expiry per due slot whose destination is not marked full, at most 16,
// lowest slot first, last set on the final one. A tick that expires
// nothing gives no result; the token walk sets the length of a request.
// Results pass through a held stage and an output register; if rsp is
// stalled the walk pauses on the next hit, without losing any result.
// Reset: all slots free, tick count zero, ms_per_tick 10.
// Depends on otb_pkg, the channel interfaces, otb_cell, otb_ctrl and
// assert_macros.svh.
`include "assert_macros.svh"
module oneshot_timer_bank import otb_pkg::*; #(
    parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
    parameter int NUM_DESTINATIONS = NUM_DEST_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    otb_req_if.sink   req,
    otb_rsp_if.source rsp,
    otb_cfg_if.sink   cfg
);

    cell_ctrl_t           cell_ctrl;
    logic                 token_start;
    logic [TIME_W-1:0]    now_ms;
    logic [TIME_W-1:0]    duration_ms;
    logic [DEST_W-1:0]    destination;
    logic [MASK_W-1:0]    full_mask;
    logic [NUM_SLOTS-1:0] token;
    logic [NUM_SLOTS-1:0] hit_vec;
    cell_hit_t            hits [NUM_SLOTS];
    cell_hit_t            hit_any;

    otb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .hit_any     (hit_any),
        .token_exit  (token[NUM_SLOTS-1]),
        .cell_ctrl   (cell_ctrl),
        .token_start (token_start),
        .now_ms      (now_ms),
        .duration_ms (duration_ms),
        .destination (destination),
        .full_mask   (full_mask)
    );

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        logic token_in;
        if (i == 0)
        begin : g_head
            assign token_in = token_start;
        end
        else
        begin : g_link
            assign token_in = token[i-1];
        end

        otb_cell #(
            .ID               (i),
            .NUM_DESTINATIONS (NUM_DESTINATIONS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .now_ms      (now_ms),
            .duration_ms (duration_ms),
            .destination (destination),
            .full_mask   (full_mask),
            .token_in    (token_in),
            .token_out   (token[i]),
            .hit         (hits[i])
        );

        assign hit_vec[i] = hits[i].hit;
    end

    // only the token holder can report, so an OR of the gated reports selects it
    always_comb
    begin
        hit_any = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            hit_any = cell_hit_t'(hit_any | hits[i]);
        end
    end

    `OTB_ASSERT_ALWAYS(a_token_onehot0, clk, rst_n, $onehot0(token))
    `OTB_ASSERT_ALWAYS(a_hit_onehot0, clk, rst_n, $onehot0(hit_vec))
    `OTB_ASSERT_ALWAYS(a_hit_has_token, clk, rst_n, (hit_vec & ~token) == '0)

endmodule
